FILE: rtl/vector_clock_store_assert.svh
// Assertion macros for the vector clock store RTL.
`ifndef VECTOR_CLOCK_STORE_ASSERT_SVH
`define VECTOR_CLOCK_STORE_ASSERT_SVH

// Plain property, checked on every clock edge outside reset.
`define VCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("vector clock store check failed");

// Implication: when ante holds, cons holds in the same cycle.
`define VCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vector clock store check failed");

`endif

FILE: rtl/vcs_pkg.sv
// Shared types and constants for the vector clock store.
`timescale 1ns / 1ps
package vcs_pkg;

  localparam int DEFAULT_NODE_SLOTS = 16;
  localparam int NODE_W    = 4;
  localparam int CNT_W     = 32;
  localparam int STAMP_W   = 48;
  localparam int CFG_W     = 5;
  localparam logic [CFG_W-1:0] KEEP_LIMIT_RST = 5'd16;

  localparam logic [2:0] CMD_INC   = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_MERGE = 3'd2;
  localparam logic [2:0] CMD_CMP   = 3'd3;
  localparam logic [2:0] CMD_GET   = 3'd4;
  localparam logic [2:0] CMD_PRUNE = 3'd5;

  localparam logic [1:0] ORD_EQUAL = 2'd0;

  typedef enum logic [2:0] {
    OP_INC, OP_SET, OP_MERGE, OP_CMP, OP_GET, OP_PRUNE, OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               ok;
    logic [NODE_W-1:0]  node;
    logic [CNT_W-1:0]   counter;
    logic [STAMP_W-1:0] stamp;
    logic               last;
  } vcs_req_t;

endpackage

FILE: rtl/vcs_front.sv
// Front end: accepts commands, decodes them and queues them for the back end.
`timescale 1ns / 1ps
module vcs_front #(
  parameter int NodeSlots = vcs_pkg::DEFAULT_NODE_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   cmd_i,
  input  logic [vcs_pkg::NODE_W-1:0]   node_i,
  input  logic [vcs_pkg::CNT_W-1:0]    counter_i,
  input  logic [vcs_pkg::STAMP_W-1:0]  stamp_i,
  input  logic                         last_i,
  output logic                         req_valid_o,
  input  logic                         req_pop_i,
  output vcs_pkg::vcs_req_t            req_o
);
  import vcs_pkg::*;

  vcs_req_t   fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  vcs_req_t   dec;
  logic       push, pop;

  always_comb begin
    dec.node    = node_i;
    dec.counter = counter_i;
    dec.stamp   = stamp_i;
    dec.last    = last_i;
    dec.ok      = 32'(node_i) < NodeSlots;
    case (cmd_i)
      CMD_INC:   dec.op = OP_INC;
      CMD_SET:   dec.op = OP_SET;
      CMD_MERGE: dec.op = OP_MERGE;
      CMD_CMP:   dec.op = OP_CMP;
      CMD_GET:   dec.op = OP_GET;
      CMD_PRUNE: dec.op = OP_PRUNE;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign busy        = count_q == 2'd2;
  assign push        = start && !busy;
  assign pop         = req_pop_i && (count_q != 2'd0);
  assign req_valid_o = count_q != 2'd0;
  assign req_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/vcs_back.sv
// Back end: slot storage, command execution, compare verdict and prune walk.
`timescale 1ns / 1ps
`include "vector_clock_store_assert.svh"
module vcs_back #(
  parameter int NodeSlots = vcs_pkg::DEFAULT_NODE_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         keep_limit_we_i,
  input  logic [vcs_pkg::CFG_W-1:0]    keep_limit_i,
  input  logic                         req_valid_i,
  output logic                         req_pop_o,
  input  vcs_pkg::vcs_req_t            req_i,
  output logic                         done_o,
  output logic [vcs_pkg::CNT_W-1:0]    value_o,
  output logic [1:0]                   ordering_o,
  output logic                         ordering_valid_o,
  output logic [vcs_pkg::CFG_W-1:0]    live_entries_o
);
  import vcs_pkg::*;

  // only 16 slots are addressable through the node field
  localparam int SLOTS = (NodeSlots < 16) ? NodeSlots : 16;
  localparam int IDXW  = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DROP = 2'd3;

  logic [1:0]         state_q, state_d;
  vcs_req_t           req_q;
  logic [CNT_W-1:0]   cnt_q   [SLOTS];
  logic [STAMP_W-1:0] stamp_q [SLOTS];
  logic [SLOTS-1:0]   seen_q, seen_d, live_vec;
  logic               lg_q, lg_d, pg_q, pg_d;
  logic [CFG_W-1:0]   max_q;
  logic [LW-1:0]      live_q, live_d;
  logic [IDXW-1:0]    scan_q, scan_d, best_q, best_d;
  logic [STAMP_W-1:0] best_stamp_q, best_stamp_d;
  logic               found_q, found_d;

  logic [IDXW-1:0]    node_idx, rd_idx, wr_idx;
  logic [CNT_W-1:0]   rd_cnt, wr_cnt;
  logic [STAMP_W-1:0] rd_stamp, wr_stamp;
  logic               wr_en;

  logic               done_d, ordv_d;
  logic [CNT_W-1:0]   value_d;
  logic [1:0]         ord_d;

  assign node_idx  = req_q.node[IDXW-1:0];
  assign rd_idx    = (state_q == S_SCAN) ? scan_q : node_idx;
  assign rd_cnt    = cnt_q[rd_idx];
  assign rd_stamp  = stamp_q[rd_idx];
  assign req_pop_o = (state_q == S_IDLE) && req_valid_i;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      live_vec[i] = cnt_q[i] != '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    seen_d       = seen_q;
    lg_d         = lg_q;
    pg_d         = pg_q;
    live_d       = live_q;
    scan_d       = scan_q;
    best_d       = best_q;
    best_stamp_d = best_stamp_q;
    found_d      = found_q;
    wr_en        = 1'b0;
    wr_idx       = node_idx;
    wr_cnt       = rd_cnt;
    wr_stamp     = rd_stamp;
    done_d       = 1'b0;
    ordv_d       = 1'b0;
    ord_d        = ORD_EQUAL;
    value_d      = req_q.ok ? rd_cnt : '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (req_q.op)
          OP_INC: begin
            wr_en    = req_q.ok;
            wr_cnt   = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
            wr_stamp = req_q.stamp;
          end
          OP_SET: begin
            wr_en    = req_q.ok;
            wr_cnt   = req_q.counter;
            wr_stamp = (req_q.counter == '0) ? '0 : req_q.stamp;
          end
          OP_MERGE: begin
            wr_en    = req_q.ok && (req_q.counter > rd_cnt);
            wr_cnt   = req_q.counter;
            wr_stamp = req_q.stamp;
          end
          OP_CMP: begin
            lg_d = lg_q | (req_q.ok && (rd_cnt > req_q.counter));
            pg_d = pg_q | (req_q.ok && (req_q.counter > rd_cnt));
            for (int i = 0; i < SLOTS; i++) begin
              seen_d[i] = seen_q[i] | (req_q.ok && (node_idx == IDXW'(i)));
            end
            if (req_q.last) begin
              // live slots the peer never sent count as local-greater
              ord_d  = {pg_d, lg_d | (|(live_vec & ~seen_d))};
              ordv_d = 1'b1;
              seen_d = '0;
              lg_d   = 1'b0;
              pg_d   = 1'b0;
            end
          end
          OP_PRUNE: begin
            if (CFG_W'(live_q) > max_q) begin
              state_d = S_SCAN;
              done_d  = 1'b0;
              scan_d  = '0;
              found_d = 1'b0;
            end
          end
          default: ;
        endcase
        if (wr_en) begin
          value_d = wr_cnt;
          if (wr_cnt != '0 && rd_cnt == '0) live_d = live_q + 1'b1;
          if (wr_cnt == '0 && rd_cnt != '0) live_d = live_q - 1'b1;
        end
      end
      S_SCAN: begin
        if (rd_cnt != '0 && (!found_q || rd_stamp < best_stamp_q)) begin
          best_d       = scan_q;
          best_stamp_d = rd_stamp;
          found_d      = 1'b1;
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == IDXW'(SLOTS - 1)) state_d = S_DROP;
      end
      S_DROP: begin
        wr_en    = 1'b1;
        wr_idx   = best_q;
        wr_cnt   = '0;
        wr_stamp = '0;
        live_d   = live_q - 1'b1;
        if (CFG_W'(live_d) > max_q) begin
          state_d = S_SCAN;
          scan_d  = '0;
          found_d = 1'b0;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          value_d = (req_q.ok && best_q != node_idx) ? rd_cnt : '0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) req_q <= req_i;
    best_q       <= best_d;
    best_stamp_q <= best_stamp_d;
    scan_q       <= scan_d;
    value_o      <= value_d;
    ordering_o   <= ord_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      seen_q           <= '0;
      lg_q             <= 1'b0;
      pg_q             <= 1'b0;
      live_q           <= '0;
      found_q          <= 1'b0;
      max_q            <= KEEP_LIMIT_RST;
      done_o           <= 1'b0;
      ordering_valid_o <= 1'b0;
      live_entries_o   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        cnt_q[i]   <= '0;
        stamp_q[i] <= '0;
      end
    end else begin
      state_q          <= state_d;
      seen_q           <= seen_d;
      lg_q             <= lg_d;
      pg_q             <= pg_d;
      live_q           <= live_d;
      found_q          <= found_d;
      done_o           <= done_d;
      ordering_valid_o <= ordv_d;
      live_entries_o   <= CFG_W'(live_d);
      if (keep_limit_we_i) max_q <= keep_limit_i;
      if (wr_en) begin
        cnt_q[wr_idx]   <= wr_cnt;
        stamp_q[wr_idx] <= wr_stamp;
      end
    end
  end

  `VCS_ASSERT(a_live_range, clk_i, rst_ni, 32'(live_q) <= SLOTS)
  `VCS_ASSERT_IMPL(a_ordv_done, clk_i, rst_ni, ordering_valid_o, done_o)
  `VCS_ASSERT_IMPL(a_ord_zero, clk_i, rst_ni, !ordering_valid_o, ordering_o == ORD_EQUAL)
  `VCS_ASSERT_IMPL(a_drop_found, clk_i, rst_ni, state_q == S_DROP, found_q)

endmodule

FILE: rtl/vector_clock_store.sv
// Top level of the vector clock store: front end, request queue and back end.
//
// Usage: drive cmd_i, node_i, counter_i, stamp_i and last_i and raise start;
// the request is taken at a rising edge where start is high and busy is low.
// Every request yields exactly one result: done_o is high for one cycle
// with value_o, ordering_o, ordering_valid_o and live_entries_o. The
// receiver cannot stall, so results are never held back.
// A two-entry queue sits between decode and execution; busy rises when it
// is full. The back end pops a request only when idle, then executes it
// and registers done_o. A prune that drops k entries walks the stamps of
// the slot registers, one slot per cycle, and clears the live slot with the
// oldest stamp, once per dropped entry. The user must write the keep limit
// through keep_limit_we_i / keep_limit_i only while the block is idle; the
// block itself does not enforce this. Reset empties the clock, the compare
// state and the queue, and sets the keep limit to 16.
`timescale 1ns / 1ps
module vector_clock_store #(
  parameter int NodeSlots = vcs_pkg::DEFAULT_NODE_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         keep_limit_we_i,
  input  logic [vcs_pkg::CFG_W-1:0]    keep_limit_i,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   cmd_i,
  input  logic [vcs_pkg::NODE_W-1:0]   node_i,
  input  logic [vcs_pkg::CNT_W-1:0]    counter_i,
  input  logic [vcs_pkg::STAMP_W-1:0]  stamp_i,
  input  logic                         last_i,
  output logic                         done_o,
  output logic [vcs_pkg::CNT_W-1:0]    value_o,
  output logic [1:0]                   ordering_o,
  output logic                         ordering_valid_o,
  output logic [vcs_pkg::CFG_W-1:0]    live_entries_o
);
  import vcs_pkg::*;

  vcs_req_t req;
  logic     req_valid, req_pop;

  vcs_front #(.NodeSlots(NodeSlots)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .node_i      (node_i),
    .counter_i   (counter_i),
    .stamp_i     (stamp_i),
    .last_i      (last_i),
    .req_valid_o (req_valid),
    .req_pop_i   (req_pop),
    .req_o       (req)
  );

  vcs_back #(.NodeSlots(NodeSlots)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .keep_limit_we_i  (keep_limit_we_i),
    .keep_limit_i     (keep_limit_i),
    .req_valid_i      (req_valid),
    .req_pop_o        (req_pop),
    .req_i            (req),
    .done_o           (done_o),
    .value_o          (value_o),
    .ordering_o       (ordering_o),
    .ordering_valid_o (ordering_valid_o),
    .live_entries_o   (live_entries_o)
  );

endmodule
